### sv/best_fit_slot_allocator_assert.svh
// Assertion macros for the best-fit slot allocator.
// Used by the top level; depends on nothing else.
`ifndef BEST_FIT_SLOT_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_SLOT_ALLOCATOR_ASSERT_SVH

// When a holds, b holds in the same cycle.
`define BFSA_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("bfsa: same-cycle check failed");

// When a holds, b holds in the next cycle.
`define BFSA_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("bfsa: next-cycle check failed");

`endif

### sv/bfsa_pkg.sv
// Shared types and constants for the best-fit slot allocator.
// Used by bfsa_cell and best_fit_slot_allocator.
package bfsa_pkg;

   localparam int OPCODE_W   = 1;
   localparam int SLOT_W     = 4;
   localparam int CAP_PORT_W = 16;
   localparam int REQ_W      = 16;

   localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Control part of the search word that walks the chain.
   typedef struct packed {
      logic active;
      logic have;
   } tok_ctl_type;

   // Commands broadcast to every cell.
   typedef struct packed {
      logic load;
      logic take;
   } cmd_type;

endpackage

### sv/best_fit_slot_allocator.sv
// Best-fit slot allocator: a load word writes one slot's capacity and frees the slot
// (slot indexes at or above NUM_SLOTS are ignored) and gives no result; an allocate
// word grants the free slot with the smallest capacity that still holds the request,
// lowest index on a tie, and returns one result (found=0 and no change when nothing
// fits). A load word writes the cell as it is accepted, and the block stays ready. After
// acceptance of an allocate word, the search word walks the chain of slot cells one cell per
// cycle, then the best fit is registered for the grant and the result is registered. The next
// word is accepted only after the grant, so an allocate word holds the input until then;
// a result still waiting in the output register stalls the grant until taken.
// Depends on bfsa_pkg and best_fit_slot_allocator_assert.svh.
`include "best_fit_slot_allocator_assert.svh"

module best_fit_slot_allocator #(
   parameter int NUM_SLOTS = 16,
   parameter int CAP_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bfsa_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [bfsa_pkg::SLOT_W-1:0]       req_slot_index,
   input  logic [bfsa_pkg::CAP_PORT_W-1:0]   req_capacity,
   input  logic [bfsa_pkg::REQ_W-1:0]        req_request_size,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_found,
   output logic [bfsa_pkg::SLOT_W-1:0]       rsp_granted_slot,
   output logic [bfsa_pkg::CAP_PORT_W-1:0]   rsp_granted_capacity
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int CMP_W = (CAP_WIDTH > bfsa_pkg::REQ_W) ? CAP_WIDTH : bfsa_pkg::REQ_W;

   bfsa_pkg::state_type             state_ff;
   bfsa_pkg::state_type             state_in;
   bfsa_pkg::cmd_type               cmd;
   logic                            start_ff;
   logic                            start_in;
   logic                            rsp_load;
   logic [bfsa_pkg::REQ_W-1:0]      req_size_ff;
   logic                            fin_have_ff;
   logic [IDX_W-1:0]                fin_idx_ff;
   logic [CAP_WIDTH-1:0]            fin_cap_ff;
   logic                            rsp_valid_ff;
   logic                            rsp_found_ff;
   logic [bfsa_pkg::SLOT_W-1:0]     rsp_slot_ff;
   logic [bfsa_pkg::CAP_PORT_W-1:0] rsp_cap_ff;

   bfsa_pkg::tok_ctl_type tok_ctl [0:NUM_SLOTS];
   logic [IDX_W-1:0]      tok_idx [0:NUM_SLOTS];
   logic [CAP_WIDTH-1:0]  tok_cap [0:NUM_SLOTS];

   // head of the chain: launch an empty search word
   assign tok_ctl[0].active = start_ff;
   assign tok_ctl[0].have   = 1'b0;
   assign tok_idx[0]        = '0;
   assign tok_cap[0]        = '0;

   for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
      bfsa_cell #(
         .CELL_IDX (k),
         .IDX_W    (IDX_W),
         .CAP_W    (CAP_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .load_slot  (req_slot_index),
         .load_cap   (CAP_WIDTH'(req_capacity)),
         .take_slot  (fin_idx_ff),
         .req_size   (req_size_ff),
         .tok_ctl_in (tok_ctl[k]),
         .tok_idx_in (tok_idx[k]),
         .tok_cap_in (tok_cap[k]),
         .tok_ctl_ff (tok_ctl[k+1]),
         .tok_idx_ff (tok_idx[k+1]),
         .tok_cap_ff (tok_cap[k+1])
      );
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      start_in  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         bfsa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == bfsa_pkg::OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  start_in = 1'b1;
                  state_in = bfsa_pkg::ST_SCAN;
               end
            end
         end
         bfsa_pkg::ST_SCAN: begin
            if (tok_ctl[NUM_SLOTS].active) begin
               state_in = bfsa_pkg::ST_FINISH;
            end
         end
         bfsa_pkg::ST_FINISH: begin
            // hold the grant until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               cmd.take = fin_have_ff;
               state_in = bfsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfsa_pkg::ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_in) begin
         req_size_ff <= req_request_size;
      end
      if (tok_ctl[NUM_SLOTS].active) begin
         fin_have_ff <= tok_ctl[NUM_SLOTS].have;
         fin_idx_ff  <= tok_idx[NUM_SLOTS];
         fin_cap_ff  <= tok_cap[NUM_SLOTS];
      end
      if (rsp_load) begin
         rsp_found_ff <= fin_have_ff;
         rsp_slot_ff  <= fin_have_ff ? bfsa_pkg::SLOT_W'(fin_idx_ff) : '0;
         rsp_cap_ff   <= fin_have_ff ? bfsa_pkg::CAP_PORT_W'(fin_cap_ff) : '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_granted_slot     = rsp_slot_ff;
   assign rsp_granted_capacity = rsp_cap_ff;

   `BFSA_ASSERT_SAME(a_tail_in_scan, clock, reset, tok_ctl[NUM_SLOTS].active,
      state_ff == bfsa_pkg::ST_SCAN)
   `BFSA_ASSERT_SAME(a_take_needs_fit, clock, reset, cmd.take,
      fin_have_ff && (state_ff == bfsa_pkg::ST_FINISH))
   `BFSA_ASSERT_SAME(a_grant_fits, clock, reset,
      (state_ff == bfsa_pkg::ST_FINISH) && fin_have_ff,
      CMP_W'(fin_cap_ff) >= CMP_W'(req_size_ff))
   `BFSA_ASSERT_NEXT(a_launch_scans, clock, reset, start_in,
      start_ff && (state_ff == bfsa_pkg::ST_SCAN))

endmodule

### sv/bfsa_cell.sv
// One slot of the allocator chain: holds the slot's capacity and taken flag,
// updates the passing search word. Depends on bfsa_pkg.
module bfsa_cell #(
   parameter int CELL_IDX = 0,
   parameter int IDX_W    = 4,
   parameter int CAP_W    = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bfsa_pkg::cmd_type            cmd,
   input  logic [bfsa_pkg::SLOT_W-1:0]  load_slot,
   input  logic [CAP_W-1:0]             load_cap,
   input  logic [IDX_W-1:0]             take_slot,
   input  logic [bfsa_pkg::REQ_W-1:0]   req_size,
   input  bfsa_pkg::tok_ctl_type        tok_ctl_in,
   input  logic [IDX_W-1:0]             tok_idx_in,
   input  logic [CAP_W-1:0]             tok_cap_in,
   output bfsa_pkg::tok_ctl_type        tok_ctl_ff,
   output logic [IDX_W-1:0]             tok_idx_ff,
   output logic [CAP_W-1:0]             tok_cap_ff
);

   localparam int CMP_W = (CAP_W > bfsa_pkg::REQ_W) ? CAP_W : bfsa_pkg::REQ_W;

   logic [CAP_W-1:0]      cap_ff;
   logic                  taken_ff;
   logic                  fits;
   logic                  better;
   bfsa_pkg::tok_ctl_type tok_ctl_in_next;
   logic [IDX_W-1:0]      tok_idx_in_next;
   logic [CAP_W-1:0]      tok_cap_in_next;

   always_comb begin
      fits   = !taken_ff && (CMP_W'(cap_ff) >= CMP_W'(req_size));
      // strict compare keeps the lower index on a tie
      better = fits && (!tok_ctl_in.have || (cap_ff < tok_cap_in));
      tok_ctl_in_next.active = tok_ctl_in.active;
      tok_ctl_in_next.have   = tok_ctl_in.have | better;
      tok_idx_in_next        = better ? IDX_W'(CELL_IDX) : tok_idx_in;
      tok_cap_in_next        = better ? cap_ff : tok_cap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff   <= 1'b1;
         tok_ctl_ff <= '0;
      end else begin
         tok_ctl_ff <= tok_ctl_in_next;
         if (cmd.load && (int'(load_slot) == CELL_IDX)) begin
            taken_ff <= 1'b0;
         end else if (cmd.take && (take_slot == IDX_W'(CELL_IDX))) begin
            taken_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      tok_idx_ff <= tok_idx_in_next;
      tok_cap_ff <= tok_cap_in_next;
      if (cmd.load && (int'(load_slot) == CELL_IDX)) begin
         cap_ff <= load_cap;
      end
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for best_fit_slot_allocator: drives load and allocate words, keeps its own copy
// of the slot table to predict every grant, and checks each result word in order.
// Depends on bfsa_pkg and the best_fit_slot_allocator RTL.
module testbench;

   localparam int NUM_SLOTS       = 16;
   localparam int CAP_WIDTH       = 16;
   localparam int ALLOC_LAT       = NUM_SLOTS + 3;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam logic [bfsa_pkg::CAP_PORT_W-1:0] CAP_MAX = '1;

   typedef struct packed {
      logic                            found;
      logic [bfsa_pkg::SLOT_W-1:0]     slot;
      logic [bfsa_pkg::CAP_PORT_W-1:0] cap;
   } grant_type;

   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic                            req_ready;
   logic [bfsa_pkg::OPCODE_W-1:0]   req_opcode       = bfsa_pkg::OP_LOAD;
   logic [bfsa_pkg::SLOT_W-1:0]     req_slot_index   = '0;
   logic [bfsa_pkg::CAP_PORT_W-1:0] req_capacity     = '0;
   logic [bfsa_pkg::REQ_W-1:0]      req_request_size = '0;
   logic                            rsp_valid;
   logic                            rsp_ready        = 1'b0;
   logic                            rsp_found;
   logic [bfsa_pkg::SLOT_W-1:0]     rsp_granted_slot;
   logic [bfsa_pkg::CAP_PORT_W-1:0] rsp_granted_capacity;

   best_fit_slot_allocator #(
      .NUM_SLOTS(NUM_SLOTS),
      .CAP_WIDTH(CAP_WIDTH)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_slot_index       (req_slot_index),
      .req_capacity         (req_capacity),
      .req_request_size     (req_request_size),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_found            (rsp_found),
      .rsp_granted_slot     (rsp_granted_slot),
      .rsp_granted_capacity (rsp_granted_capacity)
   );

   always #5 clock = ~clock;

   // Local slot table and the grants still owed by the block.
   logic [CAP_WIDTH-1:0] slot_cap_copy   [NUM_SLOTS];
   logic                 slot_taken_copy [NUM_SLOTS];
   grant_type            grant_queue[$];

   int errors          = 0;
   int cycles          = 0;
   int burst_left      = 0;
   int hold_off_asks   = 0;
   int hold_off_served = 0;
   int hold_left       = 0;
   int mode_left       = 0;
   int ready_mode      = 0;

   // Update the table copy for one accepted word; queue the grant an allocate word owes.
   function automatic void predict_grant(input logic [bfsa_pkg::OPCODE_W-1:0] op,
                                         input logic [bfsa_pkg::SLOT_W-1:0] slot,
                                         input logic [bfsa_pkg::CAP_PORT_W-1:0] cap,
                                         input logic [bfsa_pkg::REQ_W-1:0] size);
      grant_type g;
      int        best;
      best = -1;
      g = '0;
      if (op == bfsa_pkg::OP_LOAD) begin
         if (slot < NUM_SLOTS) begin
            slot_cap_copy[slot]   = cap[CAP_WIDTH-1:0];
            slot_taken_copy[slot] = 1'b0;
         end
         return;
      end
      // Strict less-than keeps the lowest index on a tie.
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (!slot_taken_copy[k] && slot_cap_copy[k] >= size &&
             (best < 0 || slot_cap_copy[k] < slot_cap_copy[best]))
            best = k;
      end
      if (best >= 0) begin
         slot_taken_copy[best] = 1'b1;
         g.found = 1'b1;
         g.slot  = best[bfsa_pkg::SLOT_W-1:0];
         g.cap   = slot_cap_copy[best];
      end
      grant_queue.push_back(g);
   endfunction

   task automatic send_word(input logic [bfsa_pkg::OPCODE_W-1:0] op,
                            input logic [bfsa_pkg::SLOT_W-1:0] slot,
                            input logic [bfsa_pkg::CAP_PORT_W-1:0] cap,
                            input logic [bfsa_pkg::REQ_W-1:0] size);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_slot_index   <= slot;
      req_capacity     <= cap;
      req_request_size <= size;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_grant(op, slot, cap, size);
   endtask

   task automatic send_load(input logic [bfsa_pkg::SLOT_W-1:0] slot,
                            input logic [bfsa_pkg::CAP_PORT_W-1:0] cap);
      send_word(bfsa_pkg::OP_LOAD, slot, cap, bfsa_pkg::REQ_W'($urandom_range(0, 65535)));
   endtask

   task automatic send_alloc(input logic [bfsa_pkg::REQ_W-1:0] size);
      send_word(bfsa_pkg::OP_ALLOC, bfsa_pkg::SLOT_W'($urandom_range(0, NUM_SLOTS - 1)),
                bfsa_pkg::CAP_PORT_W'($urandom_range(0, 65535)), size);
   endtask

   task automatic sender_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
   endtask

   task automatic wait_for_grants();
      sender_idle();
      while (grant_queue.size() != 0) @(posedge clock);
   endtask

   function automatic logic [bfsa_pkg::CAP_PORT_W-1:0] pick_capacity();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CAP_MAX;
         2, 3, 4: return bfsa_pkg::CAP_PORT_W'(16'h0100 * $urandom_range(1, 4));
         default: return bfsa_pkg::CAP_PORT_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Mostly reload taken slots and aim requests at free capacities so the search has work.
   task automatic send_random_word();
      int                         free_slots[$];
      int                         taken_slots[$];
      int                         slot;
      bit                         do_load;
      logic [CAP_WIDTH-1:0]       base;
      logic [bfsa_pkg::REQ_W-1:0] size;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (slot_taken_copy[k]) taken_slots.push_back(k);
         else free_slots.push_back(k);
      end
      if (free_slots.size() < 3) do_load = ($urandom_range(0, 3) != 0);
      else do_load = ($urandom_range(0, 99) < 45);
      if (do_load) begin
         if (taken_slots.size() > 0 && $urandom_range(0, 9) < 7)
            slot = taken_slots[$urandom_range(0, taken_slots.size() - 1)];
         else
            slot = $urandom_range(0, NUM_SLOTS - 1);
         send_load(slot[bfsa_pkg::SLOT_W-1:0], pick_capacity());
         return;
      end
      case ($urandom_range(0, 9))
         0: size = '0;
         1: size = CAP_MAX;
         2: size = bfsa_pkg::REQ_W'($urandom_range(0, 65535));
         default: begin
            if (free_slots.size() > 0) begin
               base = slot_cap_copy[free_slots[$urandom_range(0, free_slots.size() - 1)]];
               case ($urandom_range(0, 2))
                  0:       size = base;
                  1:       size = base + 1'b1;
                  default: size = base - 1'b1;
               endcase
            end else begin
               size = bfsa_pkg::REQ_W'($urandom_range(0, 65535));
            end
         end
      endcase
      send_alloc(size);
   endtask

   // Every slot is taken after reset, so nothing fits.
   task automatic test_empty_table();
      send_alloc('0);
      send_alloc(CAP_MAX);
   endtask

   task automatic test_directed_fits();
      send_load(4'd0, 16'h0200);
      send_load(4'd5, 16'h0200);
      send_load(4'd15, CAP_MAX);
      send_load(4'd3, 16'h0000);
      send_load(4'd9, 16'h0100);
      send_load(4'd10, 16'h0FFF);
      send_alloc(16'h0000);
      send_alloc(16'h0101);
      send_alloc(16'h0200);
      send_alloc(16'h0201);
      send_alloc(CAP_MAX);
      send_alloc(CAP_MAX);
      send_alloc(16'h0001);
      send_alloc(16'h0000);
      // Reload a taken slot, then overwrite it while free.
      send_load(4'd15, CAP_MAX);
      send_load(4'd15, 16'h0010);
      send_alloc(16'h0011);
      send_alloc(16'h0010);
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_random_word();
   endtask

   // Hold the result side off long enough that the block backs up into its input.
   task automatic test_backpressure();
      hold_off_asks++;
      repeat (30) send_random_word();
   endtask

   // Receiver: long hold-offs on request, otherwise a mode that changes now and then.
   always @(posedge clock) begin
      if (hold_off_served != hold_off_asks) begin
         hold_off_served = hold_off_asks;
         hold_left = HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(8, 80);
         end
         mode_left--;
         case (ready_mode)
            0, 1:    rsp_ready <= 1'b1;
            2:       rsp_ready <= ($urandom_range(0, 1) == 0);
            default: rsp_ready <= ($urandom_range(0, 5) == 0);
         endcase
      end
   end

   function automatic void report_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (grant_queue.size() == 0) begin
            errors++;
            $display("%0t: result word with none expected, found %0b slot %0d capacity %0d",
                     $time, rsp_found, rsp_granted_slot, rsp_granted_capacity);
         end else begin
            want = grant_queue.pop_front();
            if (rsp_found !== want.found)
               report_field("found", 32'(want.found), 32'(rsp_found));
            if (rsp_granted_slot !== want.slot)
               report_field("granted_slot", 32'(want.slot), 32'(rsp_granted_slot));
            if (rsp_granted_capacity !== want.cap)
               report_field("granted_capacity", 32'(want.cap), 32'(rsp_granted_capacity));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still expected", $time, grant_queue.size());
         $display("best_fit_slot_allocator: mismatch");
         $finish;
      end
   end

   initial begin
      foreach (slot_taken_copy[k]) begin
         slot_taken_copy[k] = 1'b1;
         slot_cap_copy[k]   = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_directed_fits();
      test_random_mix(400);
      test_backpressure();
      // Pause the sender until the block has returned everything.
      wait_for_grants();
      test_random_mix(480);
      wait_for_grants();
      repeat (ALLOC_LAT + 8) @(posedge clock);
      if (errors == 0)
         $display("best_fit_slot_allocator: match");
      else
         $display("best_fit_slot_allocator: mismatch");
      $finish;
   end

endmodule
